[rtl/core/sfa_pkg.sv]
// ----------------------------------------------------------------------------
// sfa_pkg: shared types and helpers for the slot allocator
// Widths, command codes, slot entry layout and the per-slot animation math.
// ----------------------------------------------------------------------------
package sfa_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam int CMD_W   = 2;
   localparam int SLOT_W  = 4;
   localparam int TYPE_W  = 8;
   localparam int GRID_W  = 8;
   localparam int FRAME_W = 4;
   localparam int DELAY_W = 3;
   localparam int SPEED_W = 2;

   localparam logic [FRAME_W-1:0] FRAME_COUNT_RST = 4'd9;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [TYPE_W-1:0]        item_type;
      logic signed [GRID_W-1:0] grid_x;
      logic signed [GRID_W-1:0] grid_y;
      logic [FRAME_W-1:0]       frame;
      logic [DELAY_W-1:0]       delay;
      logic [SPEED_W-1:0]       speed;
   } entry_type;

   typedef struct packed {
      logic    found;
      idx_type idx;
   } fit_type;

   // pointer advance with wrap at the table size
   function automatic idx_type next_idx(input idx_type i);
      if (32'(i) == SLOT_COUNT - 1) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

   // fresh entry: phase seeded from the slot number
   function automatic entry_type seed_entry(input idx_type i,
                                            input logic [TYPE_W-1:0] t,
                                            input logic signed [GRID_W-1:0] x,
                                            input logic signed [GRID_W-1:0] y);
      entry_type  e;
      logic [7:0] wide;
      wide        = 8'(i);
      e.item_type = t;
      e.grid_x    = x;
      e.grid_y    = y;
      e.frame     = 4'(wide[2:0]);
      e.delay     = 3'(wide[1:0]);
      e.speed     = 2'd2 + 2'(wide[0]);
      return e;
   endfunction

   // one animation tick for an active slot
   function automatic entry_type anim_step(input entry_type e,
                                           input logic [FRAME_W-1:0] fc);
      entry_type        r;
      logic [FRAME_W:0] f;
      r = e;
      if (e.delay == '0) begin
         f       = {1'b0, e.frame} + 5'd1;
         r.delay = 3'(e.speed);
         if (f >= {1'b0, fc}) begin
            f = '0;
         end
         r.frame = f[FRAME_W-1:0];
      end else begin
         r.delay = e.delay - 1'b1;
      end
      return r;
   endfunction

endpackage

[rtl/core/sfa_if.sv]
// ----------------------------------------------------------------------------
// sfa_if: channel interfaces of the slot allocator
// Command, response and control-register channels, valid/ready each.
// ----------------------------------------------------------------------------
interface sfa_req_if;
   logic                                valid;
   logic                                ready;
   logic [sfa_pkg::CMD_W-1:0]           command;
   logic [sfa_pkg::TYPE_W-1:0]          item_type;
   logic signed [sfa_pkg::GRID_W-1:0]   grid_x;
   logic signed [sfa_pkg::GRID_W-1:0]   grid_y;
   logic [sfa_pkg::SLOT_W-1:0]          slot_index;

   modport source (output valid, command, item_type, grid_x, grid_y, slot_index,
                   input ready);
   modport sink   (input valid, command, item_type, grid_x, grid_y, slot_index,
                   output ready);
endinterface

interface sfa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [sfa_pkg::SLOT_W-1:0]          slot;
   logic                                full_res;
   logic                                active;
   logic [sfa_pkg::TYPE_W-1:0]          out_type;
   logic signed [sfa_pkg::GRID_W-1:0]   out_grid_x;
   logic signed [sfa_pkg::GRID_W-1:0]   out_grid_y;
   logic [sfa_pkg::FRAME_W-1:0]         frame;
   logic                                last;

   modport source (output valid, slot, full_res, active, out_type, out_grid_x,
                   out_grid_y, frame, last, input ready);
   modport sink   (input valid, slot, full_res, active, out_type, out_grid_x,
                   out_grid_y, frame, last, output ready);
endinterface

interface sfa_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sfa_pkg::FRAME_W-1:0]   frame_count;

   modport source (output valid, frame_count, input ready);
   modport sink   (input valid, frame_count, output ready);
endinterface

[rtl/core/sfa_next_fit.sv]
// ----------------------------------------------------------------------------
// sfa_next_fit: next-fit free slot search
// First free slot at or after the rotating start pointer, wrapping around.
// ----------------------------------------------------------------------------
module sfa_next_fit (
   input  logic [sfa_pkg::SLOT_COUNT-1:0] in_use,
   input  sfa_pkg::idx_type               start,
   output sfa_pkg::fit_type               fit
);

   sfa_pkg::idx_type cand [sfa_pkg::SLOT_COUNT];

   // candidate index for each offset from the start pointer
   always_comb begin
      for (int n = 0; n < sfa_pkg::SLOT_COUNT; n++) begin
         if (32'(start) + 32'(n) >= 32'(sfa_pkg::SLOT_COUNT)) begin
            cand[n] = sfa_pkg::IDX_W'(32'(start) + 32'(n) - 32'(sfa_pkg::SLOT_COUNT));
         end else begin
            cand[n] = sfa_pkg::IDX_W'(32'(start) + 32'(n));
         end
      end
   end

   // lowest offset wins: scan from the far end down
   always_comb begin
      fit.found = 1'b0;
      fit.idx   = '0;
      for (int n = sfa_pkg::SLOT_COUNT - 1; n >= 0; n--) begin
         if (!in_use[cand[n]]) begin
            fit.found = 1'b1;
            fit.idx   = cand[n];
         end
      end
   end

endmodule

[rtl/core/slot_allocator_with_frame_animation.sv]
// ----------------------------------------------------------------------------
// slot_allocator_with_frame_animation: next-fit slot table with animation
// Add / remove / tick commands over a slot table held in a registered-read RAM.
// ----------------------------------------------------------------------------
//
//   channel   dir  beat carries                              notes
//   req_chan  in   command, item_type, grid_x/y, slot_index  one beat/command
//   rsp_chan  out  slot, full_res, active, type, grid, frame 1 beat, 8 on tick, 0 on unused code
//   csr_chan  in   frame_count                               always ready
//
// Add: the free-slot search runs on the in-use flops at accept.
// Remove: RAM read, then response. Tick: per slot, a RAM read in ST_TK_RD,
// then write-back (active slots only) and response in ST_TK_WR.
// A new command is taken only with the FSM idle and the response register free.
// Response stalls hold the FSM before its next response; nothing is dropped.
// Synchronous reset clears in-use and written flags, the pointer and
// frame_count (to 9); RAM contents are never cleared, unwritten entries read 0.
//
module slot_allocator_with_frame_animation (
   input  logic         clock,
   input  logic         reset,
   sfa_req_if.sink      req_chan,
   sfa_rsp_if.source    rsp_chan,
   sfa_csr_if.sink      csr_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RM_RD,
      ST_TK_RD,
      ST_TK_WR
   } state_type;

   // control
   state_type                          state_ff, state_in;
   logic [sfa_pkg::SLOT_COUNT-1:0]     in_use_ff, in_use_in;
   logic [sfa_pkg::SLOT_COUNT-1:0]     written_ff, written_in;
   sfa_pkg::idx_type                   start_ff, start_in;
   sfa_pkg::idx_type                   ctr_ff, ctr_in;
   logic [sfa_pkg::FRAME_W-1:0]        frame_count_ff, frame_count_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // response payload
   logic [sfa_pkg::SLOT_W-1:0]         slot_ff, slot_in;
   logic                               full_ff, full_in;
   logic                               active_ff, active_in;
   logic [sfa_pkg::TYPE_W-1:0]         type_ff, type_in;
   logic signed [sfa_pkg::GRID_W-1:0]  gx_ff, gx_in;
   logic signed [sfa_pkg::GRID_W-1:0]  gy_ff, gy_in;
   logic [sfa_pkg::FRAME_W-1:0]        frame_ff, frame_in;
   logic                               last_ff, last_in;

   // slot RAM
   sfa_pkg::entry_type                 mem_ff [sfa_pkg::SLOT_COUNT];
   sfa_pkg::entry_type                 rd_ff;
   logic                               rd_written_ff;
   logic                               mem_we, mem_re;
   sfa_pkg::idx_type                   mem_waddr, mem_raddr;
   sfa_pkg::entry_type                 mem_wdata;

   sfa_pkg::fit_type                   fit;
   sfa_pkg::entry_type                 rd_entry, seeded, stepped;
   sfa_pkg::idx_type                   rm_idx;
   logic                               req_acc, out_free, rm_out_of_range;

   sfa_next_fit u_next_fit (
      .in_use (in_use_ff),
      .start  (start_ff),
      .fit    (fit)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rm_idx          = req_chan.slot_index[sfa_pkg::IDX_W-1:0];
   assign rm_out_of_range = 32'(req_chan.slot_index) >= 32'(sfa_pkg::SLOT_COUNT);

   // unwritten entries read as zero
   assign rd_entry = rd_written_ff ? rd_ff : '0;
   assign seeded   = sfa_pkg::seed_entry(fit.idx, req_chan.item_type,
                                         req_chan.grid_x, req_chan.grid_y);
   assign stepped  = in_use_ff[ctr_ff] ? sfa_pkg::anim_step(rd_entry, frame_count_ff)
                                       : rd_entry;

   always_comb begin
      state_in       = state_ff;
      in_use_in      = in_use_ff;
      written_in     = written_ff;
      start_in       = start_ff;
      ctr_in         = ctr_ff;
      frame_count_in = frame_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      slot_in        = slot_ff;
      full_in        = full_ff;
      active_in      = active_ff;
      type_in        = type_ff;
      gx_in          = gx_ff;
      gy_in          = gy_ff;
      frame_in       = frame_ff;
      last_in        = last_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = '0;

      if (csr_chan.valid && csr_chan.ready) begin
         frame_count_in = csr_chan.frame_count;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_chan.command)
                  sfa_pkg::CMD_ADD: begin
                     rsp_valid_in = 1'b1;
                     last_in      = 1'b1;
                     if (fit.found) begin
                        in_use_in[fit.idx]  = 1'b1;
                        written_in[fit.idx] = 1'b1;
                        start_in            = sfa_pkg::next_idx(fit.idx);
                        mem_we              = 1'b1;
                        mem_waddr           = fit.idx;
                        mem_wdata           = seeded;
                        slot_in             = sfa_pkg::SLOT_W'(fit.idx);
                        full_in             = 1'b0;
                        active_in           = 1'b1;
                        type_in             = seeded.item_type;
                        gx_in               = seeded.grid_x;
                        gy_in               = seeded.grid_y;
                        frame_in            = seeded.frame;
                     end else begin
                        slot_in   = '0;
                        full_in   = 1'b1;
                        active_in = 1'b0;
                        type_in   = '0;
                        gx_in     = '0;
                        gy_in     = '0;
                        frame_in  = '0;
                     end
                  end
                  sfa_pkg::CMD_REMOVE: begin
                     if (rm_out_of_range) begin
                        rsp_valid_in = 1'b1;
                        slot_in      = req_chan.slot_index;
                        full_in      = 1'b0;
                        active_in    = 1'b0;
                        type_in      = '0;
                        gx_in        = '0;
                        gy_in        = '0;
                        frame_in     = '0;
                        last_in      = 1'b1;
                     end else begin
                        in_use_in[rm_idx] = 1'b0;
                        mem_re            = 1'b1;
                        mem_raddr         = rm_idx;
                        ctr_in            = rm_idx;
                        state_in          = ST_RM_RD;
                     end
                  end
                  sfa_pkg::CMD_TICK: begin
                     ctr_in   = '0;
                     state_in = ST_TK_RD;
                  end
                  default: begin
                     // unused code: taken, no beat
                  end
               endcase
            end
         end
         ST_RM_RD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               slot_in      = sfa_pkg::SLOT_W'(ctr_ff);
               full_in      = 1'b0;
               active_in    = 1'b0;
               type_in      = rd_entry.item_type;
               gx_in        = rd_entry.grid_x;
               gy_in        = rd_entry.grid_y;
               frame_in     = rd_entry.frame;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_TK_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ctr_ff;
            state_in  = ST_TK_WR;
         end
         ST_TK_WR: begin
            if (out_free) begin
               if (in_use_ff[ctr_ff]) begin
                  mem_we             = 1'b1;
                  mem_waddr          = ctr_ff;
                  mem_wdata          = stepped;
                  written_in[ctr_ff] = 1'b1;
               end
               rsp_valid_in = 1'b1;
               slot_in      = sfa_pkg::SLOT_W'(ctr_ff);
               full_in      = 1'b0;
               active_in    = in_use_ff[ctr_ff];
               type_in      = stepped.item_type;
               gx_in        = stepped.grid_x;
               gy_in        = stepped.grid_y;
               frame_in     = stepped.frame;
               last_in      = (32'(ctr_ff) == sfa_pkg::SLOT_COUNT - 1);
               if (32'(ctr_ff) == sfa_pkg::SLOT_COUNT - 1) begin
                  state_in = ST_IDLE;
               end else begin
                  ctr_in   = ctr_ff + 1'b1;
                  state_in = ST_TK_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      full_ff   <= full_in;
      active_ff <= active_in;
      type_ff   <= type_in;
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      frame_ff  <= frame_in;
      last_ff   <= last_in;
      ctr_ff    <= ctr_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         in_use_ff      <= '0;
         written_ff     <= '0;
         start_ff       <= '0;
         frame_count_ff <= sfa_pkg::FRAME_COUNT_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         in_use_ff      <= in_use_in;
         written_ff     <= written_in;
         start_ff       <= start_in;
         frame_count_ff <= frame_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // slot RAM, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff         <= mem_ff[mem_raddr];
         rd_written_ff <= written_ff[mem_raddr];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.slot       = slot_ff;
   assign rsp_chan.full_res   = full_ff;
   assign rsp_chan.active     = active_ff;
   assign rsp_chan.out_type   = type_ff;
   assign rsp_chan.out_grid_x = gx_ff;
   assign rsp_chan.out_grid_y = gy_ff;
   assign rsp_chan.frame      = frame_ff;
   assign rsp_chan.last       = last_ff;

`ifndef SYNTHESIS
   a_tick_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_chan.command == sfa_pkg::CMD_TICK |=> state_ff == ST_TK_RD)
      else $error("tick did not start the slot scan");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && full_ff |-> &in_use_ff)
      else $error("full flag with a free slot in the table");

   a_ram_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ST_IDLE || state_ff == ST_TK_WR)
      else $error("RAM write outside add or tick write-back");

   a_tick_writes_active: assert property (@(posedge clock) disable iff (reset)
      mem_we && state_ff == ST_TK_WR |-> in_use_ff[ctr_ff])
      else $error("tick wrote back an inactive slot");
`endif

endmodule
